FILE: rtl/core/assert_macros.svh
// assertion macros for the value noise core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define VN2C_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be true out of reset
`define VN2C_NEVER(lbl, cond) \
  `VN2C_ASSERT(lbl, !(cond))

`endif

FILE: rtl/core/vn2c_pkg.sv
// package: types, constants and weight table for the value noise core
`default_nettype none
package vn2c_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 16;
  localparam int WT_DEPTH  = 1 << FRAC_BITS;
  localparam int LAT_W     = 18;
  localparam int SM_W      = 22;
  localparam int WT_W      = 17;
  localparam int OUT_W     = 18;
  localparam int NSTAGE    = 10;
  localparam int HASH_LAT  = 5;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_A     = 32'd15731;
  localparam logic [31:0] HASH_B     = 32'd789221;
  localparam logic [31:0] HASH_C     = 32'd1376312589;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [17:0] ONE_Q16    = 18'd65536;

  typedef logic signed [LAT_W-1:0] lat_t;
  typedef lat_t [3:0][3:0] lat_grid_t;
  typedef logic [WT_W-1:0] wt_t;
  typedef wt_t wtab_t [WT_DEPTH];

  function automatic logic [63:0] half_weight(input logic [63:0] u);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] t;
    longint acc;
    th = (u * PI_Q30) >> 12;
    x2 = (th * th) >> 30;
    t = x2 >> 1;
    acc = longint'(t);
    for (int k = 0; k < 5; k++) begin
      t = (t * x2) >> 30;
      case (k)
        0: t = t / 12;
        1: t = t / 30;
        2: t = t / 56;
        3: t = t / 90;
        default: t = t / 132;
      endcase
      if ((k % 2) == 0) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    return (64'(acc) + 64'd16384) >> 15;
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t tab;
    logic [63:0] u;
    for (int f = 0; f < WT_DEPTH; f++) begin
      u = (64'(f) << (12 - FRAC_BITS)) & 64'd4095;
      if (u <= 64'd2048) tab[f] = WT_W'(half_weight(u));
      else tab[f] = WT_W'(64'd65536 - half_weight(64'd4096 - u));
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

endpackage
`default_nettype wire

FILE: rtl/core/vn2c_hash.sv
// five-stage lattice hash pipeline for one lattice point
`default_nettype none
module vn2c_hash
  import vn2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  input  wire logic [31:0] seed,
  output lat_t             lat
);

  logic [31:0] n0;
  logic [31:0] n_r, na_r, nb_r, nn_r, p_r, h_r;
  lat_t        lat_r;

  assign n0 = x + y * HASH_MUL_Y;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= (n0 << 13) ^ n0 ^ seed;
      nn_r  <= n_r * n_r;
      na_r  <= n_r;
      p_r   <= nn_r * HASH_A + HASH_B;
      nb_r  <= na_r;
      h_r   <= nb_r * p_r + HASH_C;
      lat_r <= lat_t'(ONE_Q16 - {1'b0, h_r[30:14]});
    end
  end

  assign lat = lat_r;

endmodule
`default_nettype wire

FILE: rtl/core/vn2c_blend.sv
// smoothing and cosine blend pipeline, five stages
`default_nettype none
module vn2c_blend
  import vn2c_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire lat_grid_t            grid,
  input  wire logic [FRAC_BITS-1:0] fx,
  input  wire logic [FRAC_BITS-1:0] fy,
  output logic [OUT_W-1:0]          noise
);

  logic signed [SM_W-1:0] sm_nxt [4];
  logic signed [SM_W-1:0] sm_r [4];
  wt_t                    wx_r, wy_r, wy2_r, wy3_r;
  logic signed [40:0]     p1_r, p2_r, p3_r;
  logic signed [SM_W-1:0] a1_r, a3_r, i1_r, i2_r, i1b_r;
  logic signed [SM_W-1:0] v;
  logic [OUT_W-1:0]       out_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sm_nxt[k] = '0;
      for (int dj = 0; dj < 3; dj++) begin
        for (int di = 0; di < 3; di++) begin
          sm_nxt[k] = sm_nxt[k] + (SM_W'($signed(grid[(k / 2) + dj][(k % 2) + di]))
                      <<< (((di == 1) ? 1 : 0) + ((dj == 1) ? 1 : 0)));
        end
      end
    end
  end

  assign v = i1b_r + SM_W'(p3_r >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) sm_r[k] <= sm_nxt[k];
      wx_r  <= WTAB[fx];
      wy_r  <= WTAB[fy];
      p1_r  <= 41'((sm_r[1] - sm_r[0]) * $signed({1'b0, wx_r}));
      p2_r  <= 41'((sm_r[3] - sm_r[2]) * $signed({1'b0, wx_r}));
      a1_r  <= sm_r[0];
      a3_r  <= sm_r[2];
      wy2_r <= wy_r;
      i1_r  <= a1_r + SM_W'(p1_r >>> 16);
      i2_r  <= a3_r + SM_W'(p2_r >>> 16);
      wy3_r <= wy2_r;
      p3_r  <= 41'((i2_r - i1_r) * $signed({1'b0, wy3_r}));
      i1b_r <= i1_r;
      out_r <= OUT_W'((v + SM_W'(8)) >>> 4);
    end
  end

  assign noise = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/value_noise_2d_cosine.sv
// top level: seeded 2d value noise, smoothed and cosine interpolated
// usage:
//  input word: in_coord_x, in_coord_y in unsigned q8.8, taken when in_valid
//  is high and in_stall low. result word: out_noise_value, signed q2.16,
//  taken when out_valid is high and out_stall low.
//  cfg_data is the seed, written when cfg_valid and cfg_ready are high;
//  cfg_ready is always high, write only while the pipeline is empty.
//  one word enters per cycle while in_stall is low.
//  stage count is set by the five-stage hash (three chained multiplies)
//  plus smoothing and two blend multiply/add pairs.
//  reset clears all valid bits and the seed to zero.
//  when the receiver stalls with a result waiting, the whole pipeline
//  holds and in_stall goes high in the same cycle; nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module value_noise_2d_cosine
  import vn2c_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COORD_W-1:0] in_coord_x,
  input  wire logic [COORD_W-1:0] in_coord_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [OUT_W-1:0] out_noise_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data
);

  logic                 en;
  logic [NSTAGE-1:0]    vld_r, vld_nxt;
  logic [31:0]          seed_r;
  logic [FRAC_BITS-1:0] fx_r [HASH_LAT];
  logic [FRAC_BITS-1:0] fy_r [HASH_LAT];
  logic [31:0]          ix, iy;
  lat_grid_t            grid;
  logic [OUT_W-1:0]     noise;

  assign en        = !vld_r[NSTAGE-1] || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign vld_nxt   = {vld_r[NSTAGE-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      seed_r <= '0;
    end else begin
      if (en) vld_r <= vld_nxt;
      if (cfg_valid) seed_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r[0] <= in_coord_x[FRAC_BITS-1:0];
      fy_r[0] <= in_coord_y[FRAC_BITS-1:0];
      for (int k = 1; k < HASH_LAT; k++) begin
        fx_r[k] <= fx_r[k-1];
        fy_r[k] <= fy_r[k-1];
      end
    end
  end

  assign ix = 32'(in_coord_x[COORD_W-1:FRAC_BITS]);
  assign iy = 32'(in_coord_y[COORD_W-1:FRAC_BITS]);

  for (genvar gj = 0; gj < 4; gj++) begin : g_row
    for (genvar gi = 0; gi < 4; gi++) begin : g_col
      vn2c_hash u_hash (
        .clk  (clk),
        .en   (en),
        .x    (ix + 32'(gi) - 32'd1),
        .y    (iy + 32'(gj) - 32'd1),
        .seed (seed_r),
        .lat  (grid[gj][gi])
      );
    end
  end

  vn2c_blend u_blend (
    .clk   (clk),
    .en    (en),
    .grid  (grid),
    .fx    (fx_r[HASH_LAT-1]),
    .fy    (fy_r[HASH_LAT-1]),
    .noise (noise)
  );

  assign out_valid       = vld_r[NSTAGE-1];
  assign out_noise_value = $signed(noise);

  `VN2C_ASSERT(a_enter, (in_valid && !in_stall) |=> vld_r[0])
  `VN2C_ASSERT(a_hold, !en |=> $stable(vld_r))
  `VN2C_NEVER(a_range, out_valid && (out_noise_value < -18'sd65535))

endmodule
`default_nettype wire
